/* hw/rtl/fat12ccf_pkg.sv */
// ----------------------------------------------------------------------------
// fat12ccf_pkg: shared types and constants
// Command and status codes, and the control and status bundles that pass
// between the chain follower's controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fat12ccf_pkg;

	localparam int unsigned ADDR_W    = 13;
	localparam int unsigned CLUSTER_W = 12;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [ADDR_W-1:0] TABLE_LENGTH_RST = 13'd6144;

	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_CONTINUE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_END      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_WRITTEN  = 2'd3;

	// Successors from 0xFF8 upward mark the end of a chain.
	localparam logic [8:0] EOC_PREFIX = 9'h1FF;
	localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
	localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

	typedef enum logic [1:0] {
		RK_WRITE,
		RK_BEYOND,
		RK_LOOKUP
	} res_kind_t;

	typedef struct packed {
		logic      mem_we;
		logic      ld_addr;
		logic      rd_en;
		logic      rd_second;
		logic      cap_byte0;
		logic      ld_out;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic beyond;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/fat12ccf_ctrl.sv */
// ----------------------------------------------------------------------------
// fat12ccf_ctrl: command sequencer
// Accepts one command at a time and steps the datapath through the write, or
// the range check and the two byte reads, and then the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12ccf_ctrl
	import fat12ccf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic [CMD_W-1:0] s_cmd,
	output logic                  s_tready,
	input  wire dp_stat_t         stat,
	output dp_cmd_t               cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_RESP
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		s_tready      = 1'b0;
		cmd.mem_we    = 1'b0;
		cmd.ld_addr   = 1'b0;
		cmd.rd_en     = 1'b0;
		cmd.rd_second = 1'b0;
		cmd.cap_byte0 = 1'b0;
		cmd.ld_out    = 1'b0;
		cmd.kind      = kind_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					priority if (s_cmd == CMD_WRITE) begin
						cmd.mem_we = 1'b1;
						kind_d     = RK_WRITE;
						state_d    = S_RESP;
					end else if (s_cmd == CMD_START || s_cmd == CMD_ADVANCE) begin
						cmd.ld_addr = 1'b1;
						state_d     = S_RD0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_RD0: begin
				if (stat.beyond) begin
					kind_d  = RK_BEYOND;
					state_d = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_RD1;
				end
			end
			S_RD1: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_second = 1'b1;
				cmd.cap_byte0 = 1'b1;
				kind_d        = RK_LOOKUP;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RK_WRITE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/fat12ccf_dpath.sv */
// ----------------------------------------------------------------------------
// fat12ccf_dpath: table store and entry unpacking
// Byte memory, table length register, address generation, range check,
// entry assembly, current cluster and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12ccf_dpath
	import fat12ccf_pkg::*;
#(
	parameter int unsigned TABLE_BYTES = 6144
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_W-1:0]    cfg_data,
	input  wire logic [CMD_W-1:0]     in_cmd,
	input  wire logic [ADDR_W-1:0]    in_write_address,
	input  wire logic [7:0]           in_write_data,
	input  wire logic [CLUSTER_W-1:0] in_cluster_index,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CLUSTER_W-1:0]      out_next_cluster,
	output logic [STATUS_W-1:0]       out_status
);

	localparam int unsigned AW = $clog2(TABLE_BYTES);
	localparam logic [ADDR_W-1:0] TB_LIMIT = ADDR_W'(TABLE_BYTES);

	logic [7:0]           mem_q [TABLE_BYTES];
	logic [7:0]           rdata_q;
	logic [7:0]           byte0_q;
	logic [ADDR_W-1:0]    table_length_q;
	logic [ADDR_W-1:0]    a0_q;
	logic                 odd_q;
	logic [CLUSTER_W-1:0] current_q;
	logic                 out_valid_q;
	logic [CLUSTER_W-1:0] out_next_q;
	logic [STATUS_W-1:0]  out_status_q;

	logic [CLUSTER_W-1:0] clus;
	logic [ADDR_W-1:0]    base;
	logic [ADDR_W-1:0]    a0_d;
	logic [ADDR_W-1:0]    top;
	logic [ADDR_W-1:0]    limit;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wr_ok;
	logic [CLUSTER_W-1:0] entry;

	// Three bytes hold each cluster pair: base byte is 3 * (cluster / 2).
	always_comb begin
		clus  = (in_cmd == CMD_ADVANCE) ? current_q : in_cluster_index;
		base  = {1'b0, clus[CLUSTER_W-1:1], 1'b0} + {2'b00, clus[CLUSTER_W-1:1]};
		a0_d  = base + {{(ADDR_W-1){1'b0}}, clus[0]};
		top   = a0_q + {{(ADDR_W-1){1'b0}}, 1'b1};
		limit = (table_length_q < TB_LIMIT) ? table_length_q : TB_LIMIT;
		rd_addr = cmd.rd_second ? top : a0_q;
		wr_ok = in_write_address < TB_LIMIT;
	end

	assign stat.beyond   = top >= limit;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.mem_we && wr_ok) begin
			mem_q[in_write_address[AW-1:0]] <= in_write_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr[AW-1:0]];
		end
		if (cmd.cap_byte0) begin
			byte0_q <= rdata_q;
		end
		if (cmd.ld_addr) begin
			a0_q  <= a0_d;
			odd_q <= clus[0];
		end
	end

	// Even entry: low byte then low nibble. Odd entry: high nibble then byte.
	always_comb begin
		if (odd_q) begin
			entry = {rdata_q, 4'((byte0_q & HIGH_NIBBLE) >> 4)};
		end else begin
			entry = {4'(rdata_q & LOW_NIBBLE), byte0_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= TABLE_LENGTH_RST;
			current_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_length_q <= cfg_data;
			end
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
				if (cmd.kind == RK_LOOKUP) begin
					current_q <= entry;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			unique case (cmd.kind)
				RK_WRITE: begin
					out_next_q   <= '0;
					out_status_q <= ST_WRITTEN;
				end
				RK_BEYOND: begin
					out_next_q   <= '0;
					out_status_q <= ST_BEYOND;
				end
				RK_LOOKUP: begin
					out_next_q   <= entry;
					out_status_q <= (entry[CLUSTER_W-1:3] == EOC_PREFIX) ? ST_END
						: ST_CONTINUE;
				end
				default: begin
					out_next_q   <= '0;
					out_status_q <= ST_WRITTEN;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign out_next_cluster = out_next_q;
	assign out_status       = out_status_q;

endmodule

`default_nettype wire

/* hw/rtl/fat12_cluster_chain_follower_core.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_chain_follower_core: FAT12 cluster chain follower
// Writes store the byte at acceptance and return status WRITTEN. Lookups
// check the range, then make the two reads of the single-port byte memory;
// beyond the table the reads are skipped. An unused command yields no result.
// A result waiting for m_tready stalls the next one.
// Reset clears the current cluster and sets the table length to 6144; the
// table bytes stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fat12_cluster_chain_follower_core
	import fat12ccf_pkg::*;
#(
	parameter int unsigned TABLE_BYTES = 6144
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: table_length, written whenever cfg_we is high.
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_data,
	// Command stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata: write_address [12:0], write_data [20:13], cluster_index [32:21]
	input  wire logic [39:0] s_tdata,
	// s_tuser: cmd [1:0]
	input  wire logic [1:0]  s_tuser,
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata: next_cluster [11:0]
	output logic [15:0]      m_tdata,
	// m_tuser: status [1:0]
	output logic [1:0]       m_tuser
);

	// The controller only sequences; every stored value lives in the datapath.
	// The output register there lets a new command be accepted while the
	// previous result still waits for m_tready.
	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [CLUSTER_W-1:0] next_cluster;

	fat12ccf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_cmd    (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath computes the first byte address 3 * (cluster / 2) plus the
	// parity at acceptance, checks the top byte against the table length, then
	// reads the two bytes in consecutive cycles before unpacking the entry.
	fat12ccf_dpath #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.in_cmd           (s_tuser),
		.in_write_address (s_tdata[12:0]),
		.in_write_data    (s_tdata[20:13]),
		.in_cluster_index (s_tdata[32:21]),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_next_cluster (next_cluster),
		.out_status       (m_tuser)
	);

	assign m_tdata = {4'b0000, next_cluster};

endmodule

`default_nettype wire
